[design/button_event_scanner_macros.svh]
// Assertion helpers for the keypad scanner; clocked on clk, quiet in reset.
`ifndef BUTTON_EVENT_SCANNER_MACROS_SVH
`define BUTTON_EVENT_SCANNER_MACROS_SVH

// Condition that must hold at every edge
`define BES_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next
`define BES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/bes_pkg.sv]
package bes_pkg;

    localparam int BUTTON_COUNT_DEF = 9;
    localparam int TIME_W           = 48;
    localparam int REG_W            = 32;
    localparam int CODE_W           = 4;
    localparam int CFG_INDEX_W      = 2;
    localparam int SCAN_DEPTH       = 2;
    localparam int RES_DEPTH        = 4;
    localparam int CENTER_BUTTON    = 4;
    localparam int LONG_BUTTON      = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_LONG_HOLD  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_INT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INVERT     = 2'd2;

    localparam logic [REG_W-1:0] LONG_HOLD_DEFAULT  = 32'd1000000;
    localparam logic [REG_W-1:0] REPEAT_INT_DEFAULT = 32'd200000;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } bes_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } bes_fifo_stat_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              is_long;
        logic              last;
    } bes_event_t;

    // chord code for a button held after the centre; zero where none applies
    function automatic logic [CODE_W-1:0] chord_code(input logic [CODE_W-1:0] btn);
        logic [CODE_W-1:0] res;
        case (btn)
            4'd1:    res = 4'd9;
            4'd3:    res = 4'd10;
            4'd5:    res = 4'd11;
            4'd6:    res = 4'd12;
            4'd7:    res = 4'd13;
            4'd8:    res = 4'd14;
            default: res = 4'd0;
        endcase
        return res;
    endfunction

endpackage

[design/bes_fifo.sv]
module bes_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  logic [WIDTH-1:0]        wr_data,
    input  logic                    rd_en,
    output logic [WIDTH-1:0]        rd_data,
    output bes_pkg::bes_fifo_stat_t stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_wr;
    logic             do_rd;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[design/bes_front.sv]
module bes_front #(
    parameter int BUTTON_COUNT = bes_pkg::BUTTON_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [BUTTON_COUNT-1:0]     scan_bits,
    input  logic [bes_pkg::TIME_W-1:0]  now_time,
    input  logic [BUTTON_COUNT-1:0]     invert_bits,
    input  logic                        scan_rd,
    output logic [BUTTON_COUNT-1:0]     scan_down,
    output logic [bes_pkg::TIME_W-1:0]  scan_time,
    output bes_pkg::bes_fifo_stat_t     scan_stat
);

    localparam int EW = BUTTON_COUNT + bes_pkg::TIME_W;

    logic [BUTTON_COUNT-1:0] down_mask;
    logic [EW-1:0]           entry_in;
    logic [EW-1:0]           entry_out;

    // active low after inversion: a set bit here means the button is down
    assign down_mask = ~(scan_bits ^ invert_bits);
    assign entry_in  = {down_mask, now_time};
    assign full      = scan_stat.full;
    assign scan_down = entry_out[EW-1:bes_pkg::TIME_W];
    assign scan_time = entry_out[bes_pkg::TIME_W-1:0];

    bes_fifo #(
        .WIDTH (EW),
        .DEPTH (bes_pkg::SCAN_DEPTH)
    ) u_scan_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (entry_in),
        .rd_en   (scan_rd),
        .rd_data (entry_out),
        .stat    (scan_stat)
    );

endmodule

[design/bes_back.sv]
module bes_back #(
    parameter int BUTTON_COUNT = bes_pkg::BUTTON_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bes_pkg::bes_fifo_stat_t     scan_stat,
    input  logic [BUTTON_COUNT-1:0]     scan_down,
    input  logic [bes_pkg::TIME_W-1:0]  scan_time,
    output logic                        scan_rd,
    input  logic [bes_pkg::REG_W-1:0]   long_hold,
    input  logic [bes_pkg::REG_W-1:0]   repeat_int,
    input  bes_pkg::bes_fifo_stat_t     res_stat,
    output logic                        res_wr,
    output bes_pkg::bes_event_t         res_data
);

    localparam int IW     = $clog2(BUTTON_COUNT);
    localparam int TW     = bes_pkg::TIME_W;
    localparam int CODE_W = bes_pkg::CODE_W;

    bes_pkg::bes_state_t state_reg;
    bes_pkg::bes_state_t state_next;

    logic [IW-1:0]           idx_reg;
    logic [BUTTON_COUNT-1:0] down_reg;
    logic [TW-1:0]           now_reg;
    logic                    ctr_held_reg;
    logic [TW-1:0]           ctr_stamp_reg;

    logic [BUTTON_COUNT-1:0] held_reg;
    logic [BUTTON_COUNT-1:0] flag_reg;
    logic [TW-1:0]           press_reg [BUTTON_COUNT];
    logic [TW-1:0]           sent_reg  [BUTTON_COUNT];
    logic                    long_done_reg;

    logic                    pend_valid_reg;
    logic [CODE_W-1:0]       pend_code_reg;
    logic                    pend_long_reg;

    // per-step results for the button under idx_reg
    logic                    held_next;
    logic                    flag_next;
    logic [TW-1:0]           press_next;
    logic [TW-1:0]           sent_next;
    logic                    long_done_next;
    logic                    emit;
    logic [CODE_W-1:0]       emit_code;
    logic                    emit_long;

    logic                    step;
    logic                    flush_wr;
    logic                    last_idx;

    logic                    cur_down;
    logic                    pressed;
    logic                    released;
    logic [TW-1:0]           eff_press;
    logic                    eff_flag;
    logic [TW-1:0]           el_press;
    logic [TW-1:0]           el_sent;
    logic [CODE_W-1:0]       chord;
    logic                    chord_on;
    logic                    is_center;
    logic                    is_long_btn;

    assign last_idx = (idx_reg == IW'(BUTTON_COUNT - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bes_pkg::ST_IDLE:
            begin
                if (scan_rd)
                begin
                    state_next = bes_pkg::ST_RUN;
                end
            end
            bes_pkg::ST_RUN:
            begin
                if (step && last_idx)
                begin
                    state_next = bes_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bes_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs; the idle cycle also hands over the scan's final event
    always_comb
    begin
        step     = 1'b0;
        flush_wr = 1'b0;
        scan_rd  = 1'b0;
        res_wr   = 1'b0;
        res_data = '0;
        case (state_reg)
            bes_pkg::ST_IDLE:
            begin
                flush_wr         = pend_valid_reg && !res_stat.full;
                scan_rd          = !scan_stat.empty && (!pend_valid_reg || !res_stat.full);
                res_wr           = flush_wr;
                res_data.code    = pend_code_reg;
                res_data.is_long = pend_long_reg;
                res_data.last    = 1'b1;
            end
            bes_pkg::ST_RUN:
            begin
                step             = !res_stat.full;
                res_wr           = step && emit && pend_valid_reg;
                res_data.code    = pend_code_reg;
                res_data.is_long = pend_long_reg;
                res_data.last    = 1'b0;
            end
            default:
            begin
                step = 1'b0;
            end
        endcase
    end

    // button step
    always_comb
    begin
        cur_down    = down_reg[idx_reg];
        pressed     = cur_down && !held_reg[idx_reg];
        released    = !cur_down && held_reg[idx_reg];
        eff_press   = pressed ? now_reg : press_reg[idx_reg];
        eff_flag    = pressed ? 1'b0 : flag_reg[idx_reg];
        el_press    = now_reg - eff_press;
        el_sent     = now_reg - sent_reg[idx_reg];
        chord       = bes_pkg::chord_code(CODE_W'(idx_reg));
        chord_on    = ctr_held_reg && (ctr_stamp_reg < eff_press);
        is_center   = (idx_reg == IW'(bes_pkg::CENTER_BUTTON));
        is_long_btn = (idx_reg == IW'(bes_pkg::LONG_BUTTON));

        held_next      = cur_down;
        flag_next      = eff_flag;
        press_next     = eff_press;
        sent_next      = sent_reg[idx_reg];
        long_done_next = long_done_reg;
        emit           = 1'b0;
        emit_code      = CODE_W'(idx_reg);
        emit_long      = 1'b0;

        if (released && is_long_btn)
        begin
            if (!long_done_reg)
            begin
                emit = 1'b1;
            end
            else
            begin
                long_done_next = 1'b0;
            end
        end

        if (cur_down)
        begin
            if (is_center)
            begin
                if (!eff_flag)
                begin
                    emit      = 1'b1;
                    flag_next = 1'b1;
                    sent_next = now_reg;
                end
            end
            else if (chord_on)
            begin
                if ((chord != '0) && !eff_flag)
                begin
                    emit      = 1'b1;
                    emit_code = chord;
                    flag_next = 1'b1;
                    sent_next = now_reg;
                end
            end
            else if (is_long_btn)
            begin
                if (!long_done_reg && (el_press > {{(TW - bes_pkg::REG_W){1'b0}}, long_hold}))
                begin
                    emit           = 1'b1;
                    emit_long      = 1'b1;
                    long_done_next = 1'b1;
                end
            end
            else
            begin
                if (!eff_flag)
                begin
                    emit      = 1'b1;
                    flag_next = 1'b1;
                    sent_next = now_reg;
                end
                else if ((idx_reg != '0) &&
                         (el_sent > {{(TW - bes_pkg::REG_W){1'b0}}, repeat_int}))
                begin
                    emit      = 1'b1;
                    sent_next = now_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bes_pkg::ST_IDLE;
            idx_reg        <= '0;
            held_reg       <= '0;
            flag_reg       <= '0;
            long_done_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (scan_rd)
            begin
                idx_reg <= '0;
            end
            else if (step)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (step)
            begin
                held_reg[idx_reg] <= held_next;
                flag_reg[idx_reg] <= flag_next;
                long_done_reg     <= long_done_next;
            end
            if (flush_wr)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (step && emit)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_rd)
        begin
            down_reg      <= scan_down;
            now_reg       <= scan_time;
            // centre snapshot as it stood before this scan
            ctr_held_reg  <= held_reg[IW'(bes_pkg::CENTER_BUTTON)];
            ctr_stamp_reg <= press_reg[IW'(bes_pkg::CENTER_BUTTON)];
        end
        if (step)
        begin
            press_reg[idx_reg] <= press_next;
            sent_reg[idx_reg]  <= sent_next;
        end
        if (step && emit)
        begin
            pend_code_reg <= emit_code;
            pend_long_reg <= emit_long;
        end
    end

endmodule

[design/button_event_scanner.sv]
// Channel   Direction  Handshake            Payload
// scan      in         push / full          scan_bits, now_time
// event     out        empty / pop          button_code, is_long, last_event
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A scan runs through the button sequencer as a load step (which also
// hands over the previous scan's final event) and then one step per button.
// The sequencer holds while the event queue is full; a two-entry scan queue
// keeps push open meanwhile. Reset is asynchronous, active low: all buttons
// read as released and registers return to their default values.
`include "button_event_scanner_macros.svh"

module button_event_scanner #(
    parameter int BUTTON_COUNT = bes_pkg::BUTTON_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [BUTTON_COUNT-1:0]          scan_bits,
    input  logic [bes_pkg::TIME_W-1:0]       now_time,
    output logic                             empty,
    input  logic                             pop,
    output logic [bes_pkg::CODE_W-1:0]       button_code,
    output logic                             is_long,
    output logic                             last_event,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bes_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bes_pkg::REG_W-1:0]        cfg_data
);

    logic [bes_pkg::REG_W-1:0] long_hold_reg;
    logic [bes_pkg::REG_W-1:0] repeat_reg;
    logic [BUTTON_COUNT-1:0]   invert_reg;

    bes_pkg::bes_fifo_stat_t     scan_stat;
    logic [BUTTON_COUNT-1:0]     scan_down;
    logic [bes_pkg::TIME_W-1:0]  scan_time;
    logic                        scan_rd;
    bes_pkg::bes_fifo_stat_t     res_stat;
    logic                        res_wr;
    bes_pkg::bes_event_t         res_wdata;
    bes_pkg::bes_event_t         res_rdata;
    logic                        cfg_wr;
    logic                        cfg_hold_wr;

    assign cfg_ready   = 1'b1;
    assign cfg_wr      = cfg_valid && cfg_ready;
    assign cfg_hold_wr = cfg_wr && (cfg_index == bes_pkg::REG_LONG_HOLD);
    assign empty       = res_stat.empty;
    assign button_code = res_rdata.code;
    assign is_long     = res_rdata.is_long;
    assign last_event  = res_rdata.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_hold_reg <= bes_pkg::LONG_HOLD_DEFAULT;
            repeat_reg    <= bes_pkg::REPEAT_INT_DEFAULT;
            invert_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                bes_pkg::REG_LONG_HOLD:  long_hold_reg <= cfg_data;
                bes_pkg::REG_REPEAT_INT: repeat_reg    <= cfg_data;
                bes_pkg::REG_INVERT:     invert_reg    <= cfg_data[BUTTON_COUNT-1:0];
                default:                 invert_reg    <= invert_reg;
            endcase
        end
    end

    bes_front #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .scan_bits   (scan_bits),
        .now_time    (now_time),
        .invert_bits (invert_reg),
        .scan_rd     (scan_rd),
        .scan_down   (scan_down),
        .scan_time   (scan_time),
        .scan_stat   (scan_stat)
    );

    bes_back #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_stat  (scan_stat),
        .scan_down  (scan_down),
        .scan_time  (scan_time),
        .scan_rd    (scan_rd),
        .long_hold  (long_hold_reg),
        .repeat_int (repeat_reg),
        .res_stat   (res_stat),
        .res_wr     (res_wr),
        .res_data   (res_wdata)
    );

    bes_fifo #(
        .WIDTH ($bits(bes_pkg::bes_event_t)),
        .DEPTH (bes_pkg::RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res_wdata),
        .rd_en   (pop),
        .rd_data (res_rdata),
        .stat    (res_stat)
    );

    `BES_ASSERT_ALWAYS(a_res_no_overrun, !res_wr || !res_stat.full, "event queue overrun")
    `BES_ASSERT_ALWAYS(a_scan_no_underrun, !scan_rd || !scan_stat.empty, "scan queue underrun")
    `BES_ASSERT_NEXT(a_last_gap, res_wr && res_wdata.last, !res_wr, "event after final event")
    `BES_ASSERT_NEXT(a_cfg_hold, cfg_hold_wr, long_hold_reg == $past(cfg_data), "hold time lost")

endmodule

[verif/button_event_scanner_test.sv]
module button_event_scanner_test;

    localparam int NBTN             = bes_pkg::BUTTON_COUNT_DEF;
    localparam int TIME_W           = bes_pkg::TIME_W;
    localparam int REG_W            = bes_pkg::REG_W;
    localparam int CODE_W           = bes_pkg::CODE_W;
    localparam int CFG_INDEX_W      = bes_pkg::CFG_INDEX_W;
    localparam int CENTER_BUTTON    = bes_pkg::CENTER_BUTTON;
    localparam int LONG_BUTTON      = bes_pkg::LONG_BUTTON;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int SETTLE_CYCLES    = 64;
    localparam int HOLD_CYCLES      = 500;
    localparam int NO_REPEAT_BUTTON = 0;
    localparam int REPEAT_DEMO      = 5;
    localparam int RANDOM_SCANS     = 45;

    localparam logic [CODE_W-1:0]      CHORD_FIRST = 4'd9;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED  = 2'd3;
    localparam logic [REG_W-1:0]       REG_MAX     = '1;
    localparam logic [TIME_W-1:0]      TIME_MAX    = '1;

    // pressed-button masks for the directed part
    localparam logic [NBTN-1:0] NONE_DOWN = '0;
    localparam logic [NBTN-1:0] ALL_DOWN  = '1;
    localparam logic [NBTN-1:0] CTR_DOWN  = NBTN'(1 << CENTER_BUTTON);
    localparam logic [NBTN-1:0] LONG_DOWN = NBTN'(1 << LONG_BUTTON);
    localparam logic [NBTN-1:0] REP_DOWN  = NBTN'(1 << REPEAT_DEMO);
    localparam logic [NBTN-1:0] B1_DOWN   = NBTN'(1 << 1);

    typedef struct {
        logic [NBTN-1:0]   mask;
        logic [TIME_W-1:0] stamp;
    } scan_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic [NBTN-1:0] scan_bits = '0;
    logic [TIME_W-1:0] now_time = '0;
    logic empty;
    logic pop = 1'b0;
    logic [CODE_W-1:0] button_code;
    logic is_long;
    logic last_event;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0] cfg_data = '0;

    button_event_scanner u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .scan_bits   (scan_bits),
        .now_time    (now_time),
        .empty       (empty),
        .pop         (pop),
        .button_code (button_code),
        .is_long     (is_long),
        .last_event  (last_event),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // keypad state as the block should hold it
    logic [REG_W-1:0]  hold_cfg   = bes_pkg::LONG_HOLD_DEFAULT;
    logic [REG_W-1:0]  repeat_cfg = bes_pkg::REPEAT_INT_DEFAULT;
    logic [NBTN-1:0]   invert_cfg = '0;
    logic              btn_held [NBTN];
    logic [TIME_W-1:0] press_at [NBTN];
    logic [TIME_W-1:0] click_at [NBTN];
    logic              clicked  [NBTN];
    logic              long_sent = 1'b0;

    initial
    begin
        for (int i = 0; i < NBTN; i++)
        begin
            btn_held[i] = 1'b0;
            press_at[i] = '0;
            click_at[i] = '0;
            clicked[i]  = 1'b0;
        end
    end

    scan_item_t pending_scans[$];
    bes_pkg::bes_event_t expected_events[$];
    bes_pkg::bes_event_t want_event;

    int mismatch_count = 0;
    int cycle_count = 0;
    int gap_left = 0;
    int burst_left = 1;
    int hold_left = 0;
    logic hold_req = 1'b0;
    logic [15:0] pop_pattern = '1;
    logic [3:0] pop_phase = '0;

    task automatic report_mismatch(input string what);
        $display("ERROR cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    function automatic bes_pkg::bes_event_t make_event(input logic [CODE_W-1:0] code,
                                                       input logic lng);
        bes_pkg::bes_event_t ev;
        ev.code    = code;
        ev.is_long = lng;
        ev.last    = 1'b0;
        return ev;
    endfunction

    task automatic predict_scan(input logic [NBTN-1:0] raw, input logic [TIME_W-1:0] now);
        logic [NBTN-1:0]     up;
        logic                ctr_was_held;
        logic [TIME_W-1:0]   ctr_pressed_at;
        logic [TIME_W-1:0]   held_for;
        logic [CODE_W-1:0]   chord;
        bes_pkg::bes_event_t evs[$];
        bes_pkg::bes_event_t ev;
        up = raw ^ invert_cfg;
        // centre as it stood before this scan
        ctr_was_held   = btn_held[CENTER_BUTTON];
        ctr_pressed_at = press_at[CENTER_BUTTON];
        for (int i = 0; i < NBTN; i++)
        begin
            if (!up[i] && !btn_held[i])
            begin
                press_at[i] = now;
                click_at[i] = '0;
                clicked[i]  = 1'b0;
                btn_held[i] = 1'b1;
            end
            if (up[i] && btn_held[i])
            begin
                if (i == LONG_BUTTON)
                begin
                    if (!long_sent)
                        evs.push_back(make_event(CODE_W'(LONG_BUTTON), 1'b0));
                    long_sent = 1'b0;
                end
                btn_held[i] = 1'b0;
            end
            if (!btn_held[i])
                continue;

            if (i == CENTER_BUTTON)
            begin
                if (!clicked[i])
                begin
                    evs.push_back(make_event(CODE_W'(i), 1'b0));
                    clicked[i]  = 1'b1;
                    click_at[i] = now;
                end
            end
            else if (ctr_was_held && ctr_pressed_at < press_at[i])
            begin
                // chord codes run over buttons 1, 3, 5..8 in that order
                if (i != NO_REPEAT_BUTTON && i != LONG_BUTTON && !clicked[i])
                begin
                    chord = CHORD_FIRST + CODE_W'((i == 1) ? 0 : ((i == 3) ? 1 : i - 3));
                    evs.push_back(make_event(chord, 1'b0));
                    clicked[i]  = 1'b1;
                    click_at[i] = now;
                end
            end
            else if (i == LONG_BUTTON)
            begin
                held_for = now - press_at[i];
                if (!long_sent && held_for > hold_cfg)
                begin
                    evs.push_back(make_event(CODE_W'(LONG_BUTTON), 1'b1));
                    long_sent = 1'b1;
                end
            end
            else
            begin
                if (!clicked[i])
                begin
                    evs.push_back(make_event(CODE_W'(i), 1'b0));
                    clicked[i]  = 1'b1;
                    click_at[i] = now;
                end
                held_for = now - click_at[i];
                if (i != NO_REPEAT_BUTTON && held_for > repeat_cfg)
                begin
                    evs.push_back(make_event(CODE_W'(i), 1'b0));
                    click_at[i] = now;
                end
            end
        end
        foreach (evs[k])
        begin
            ev = evs[k];
            ev.last = (k == evs.size() - 1);
            expected_events.push_back(ev);
        end
    endtask

    // driver: bursts of items with random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                predict_scan(scan_bits, now_time);
                void'(pending_scans.pop_front());
            end
            if (!push || !full)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    push <= 1'b0;
                end
                else if (pending_scans.size() != 0)
                begin
                    push      <= 1'b1;
                    scan_bits <= pending_scans[0].mask;
                    now_time  <= pending_scans[0].stamp;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                    end
                    else
                        burst_left--;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // long hold-off of the receiver, started on request
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_req)
            hold_left <= HOLD_CYCLES;
    end

    // monitor: checks each accepted event, stalls on a rotating pattern
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_events.size() == 0)
                    report_mismatch($sformatf("event code %0d long %0b last %0b, none expected",
                                              button_code, is_long, last_event));
                else
                begin
                    want_event = expected_events.pop_front();
                    if (button_code !== want_event.code || is_long !== want_event.is_long ||
                        last_event !== want_event.last)
                        report_mismatch($sformatf(
                            "event code %0d long %0b last %0b, want %0d %0b %0b",
                            button_code, is_long, last_event,
                            want_event.code, want_event.is_long, want_event.last));
                end
            end
            if (pop_phase == 0)
                pop_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            pop <= (hold_left == 0) && pop_pattern[pop_phase];
            pop_phase = pop_phase + 1'b1;
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout: %0d events outstanding", expected_events.size());
        $display("Mismatches found");
        $finish;
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [REG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            bes_pkg::REG_LONG_HOLD:  hold_cfg = value;
            bes_pkg::REG_REPEAT_INT: repeat_cfg = value;
            bes_pkg::REG_INVERT:     invert_cfg = value[NBTN-1:0];
            default:                 ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_config(input logic [REG_W-1:0] hold, input logic [REG_W-1:0] rep,
                                input logic [NBTN-1:0] inv);
        write_reg(bes_pkg::REG_LONG_HOLD, hold);
        write_reg(bes_pkg::REG_REPEAT_INT, rep);
        write_reg(bes_pkg::REG_INVERT, REG_W'(inv));
    endtask

    task automatic queue_scan(input logic [NBTN-1:0] pressed, input logic [TIME_W-1:0] t);
        pending_scans.push_back('{~pressed ^ invert_cfg, t});
    endtask

    // buttons mostly stay put between scans, so holds, repeats and chords build up
    task automatic add_random_scans(input int count, input logic [TIME_W-1:0] t_start,
                                    input int unsigned step_max);
        logic [NBTN-1:0]   down;
        logic [TIME_W-1:0] t;
        logic [63:0]       wide;
        int                roll;
        down = '0;
        t = t_start;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
                down = NBTN'($urandom_range(0, 511));
            else
                for (int b = 0; b < NBTN; b++)
                    if ($urandom_range(0, 5) == 0)
                        down[b] = ~down[b];
            roll = $urandom_range(0, 99);
            if (roll < 4)
                t = t - TIME_W'($urandom_range(0, step_max));
            else if (roll < 6)
            begin
                wide = {$urandom, $urandom};
                t = wide[TIME_W-1:0];
            end
            else
                t = t + TIME_W'($urandom_range(0, step_max));
            queue_scan(down, t);
        end
    endtask

    task automatic wait_drained();
        while (pending_scans.size() != 0 || push || expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic request_holdoff();
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
    endtask

    initial
    begin
        logic [63:0] wide;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values
        queue_scan(NONE_DOWN, 0);
        queue_scan(ALL_DOWN, 0);
        queue_scan(ALL_DOWN, 200001);
        queue_scan(ALL_DOWN, 1000001);
        queue_scan(NONE_DOWN, 1000002);
        queue_scan(CTR_DOWN, 2000000);
        queue_scan(ALL_DOWN, 2000010);          // chords after the centre
        queue_scan(ALL_DOWN, 4000000);
        queue_scan(CTR_DOWN, 4000001);          // short click, no long was sent
        queue_scan(NONE_DOWN, 4000002);
        queue_scan(LONG_DOWN, 5000000);
        queue_scan(NONE_DOWN, 5000001);
        queue_scan(REP_DOWN, 6000000);
        queue_scan(REP_DOWN, 5000000);          // clock stepping back
        queue_scan(LONG_DOWN, TIME_MAX);
        queue_scan(LONG_DOWN, 0);               // wrapped by one unit
        queue_scan(LONG_DOWN, 1000001);
        queue_scan(LONG_DOWN | CTR_DOWN, 1000002);
        queue_scan(NONE_DOWN, 1000003);
        wait_drained();

        write_config('0, '0, '1);
        queue_scan(ALL_DOWN, 10);
        queue_scan(ALL_DOWN, 11);
        queue_scan(NONE_DOWN, 12);
        queue_scan(CTR_DOWN, 20);
        queue_scan(ALL_DOWN, 20);               // same stamp as centre: no chord
        queue_scan(NONE_DOWN, 21);
        wait_drained();

        write_config(REG_MAX, REG_MAX, '0);
        write_reg(REG_UNUSED, '0);
        queue_scan(B1_DOWN | LONG_DOWN, 100);
        queue_scan(B1_DOWN | LONG_DOWN, 48'd4294967395);    // exactly 2^32-1 later
        queue_scan(B1_DOWN | LONG_DOWN, 48'd4294967396);
        queue_scan(NONE_DOWN, 48'd4294967397);
        wait_drained();

        write_config($urandom_range(0, 200), $urandom_range(0, 100),
                     NBTN'($urandom_range(0, 511)));
        request_holdoff();
        add_random_scans(RANDOM_SCANS, TIME_W'($urandom), 80);
        wait_drained();

        write_config('0, '0, '0);
        add_random_scans(RANDOM_SCANS, '0, 5);
        wait_drained();

        write_config(REG_MAX, REG_MAX, '1);
        add_random_scans(RANDOM_SCANS, TIME_MAX - 48'h2_0000_0000, 32'hFFFF_FFFF);
        wait_drained();

        write_config($urandom_range(0, 400), $urandom_range(0, 150),
                     NBTN'($urandom_range(0, 511)));
        request_holdoff();
        wide = {$urandom, $urandom};
        add_random_scans(RANDOM_SCANS, wide[TIME_W-1:0], 150);
        wait_drained();

        write_config($urandom_range(20, 90), $urandom_range(5, 40),
                     NBTN'($urandom_range(0, 511)));
        add_random_scans(RANDOM_SCANS, TIME_MAX - 2000, 60);
        wait_drained();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
